// ----- hdl/gpf_pkg.sv -----
`timescale 1ns / 1ps

package gpf_pkg;

  localparam int MAX_CARDS = 1024;
  localparam int MAX_ROWS  = 512;
  localparam int MAX_COLS  = 512;

  localparam int CARD_AW = $clog2(MAX_CARDS);
  localparam int CNT_W   = $clog2(MAX_CARDS + 1);
  localparam int NODES   = MAX_ROWS + MAX_COLS;
  localparam int NODE_AW = $clog2(NODES);
  localparam int NODE_W  = $clog2(NODES + 1);
  localparam int POS_W   = 10;
  localparam int VAL_W   = 32;
  localparam int SUM_W   = 42;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_COL_COUNT = CFG_IDX_W'(1);

  typedef struct packed {
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
    logic [VAL_W-1:0] value;
  } card_t;

  typedef struct packed {
    logic load_fire;
    logic job_start;
    logic init_step;
    logic key_rd;
    logic key_latch;
    logic shift_rd;
    logic shift_cmp;
    logic i_clr;
    logic card_rd;
    logic card_chk;
    logic find_rd;
    logic find_cmp;
    logic merge;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic init_last;
    logic sort_more;
    logic shift_lt;
    logic sort_last;
    logic card_ok;
    logic is_root;
    logic find_v;
    logic proc_last;
    logic out_pend;
  } dp_stat_t;

endpackage

// ----- hdl/gpf_if.sv -----
`timescale 1ns / 1ps

interface gpf_card_if;
  logic                      valid;
  logic                      ready;
  logic [gpf_pkg::POS_W-1:0] card_row;
  logic [gpf_pkg::POS_W-1:0] card_col;
  logic [gpf_pkg::VAL_W-1:0] card_value;
  logic                      last_card;
  modport source (output valid, card_row, card_col, card_value, last_card, input ready);
  modport sink (input valid, card_row, card_col, card_value, last_card, output ready);
endinterface

interface gpf_result_if;
  logic                      valid;
  logic                      ready;
  logic [gpf_pkg::SUM_W-1:0] total_weight;
  modport source (output valid, total_weight, input ready);
  modport sink (input valid, total_weight, output ready);
endinterface

interface gpf_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [gpf_pkg::CFG_IDX_W-1:0] index;
  logic [gpf_pkg::POS_W-1:0]     data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- hdl/gpf_ctrl.sv -----
`timescale 1ns / 1ps

module gpf_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_last,
  output logic                in_ready,
  output gpf_pkg::ctrl_cmd_t  cmd,
  input  gpf_pkg::dp_stat_t   stat
);

  typedef enum logic [13:0] {
    S_LOAD     = 14'b00000000000001,
    S_START    = 14'b00000000000010,
    S_INIT     = 14'b00000000000100,
    S_KEY_RD   = 14'b00000000001000,
    S_KEY_WT   = 14'b00000000010000,
    S_SH_RD    = 14'b00000000100000,
    S_SH_CMP   = 14'b00000001000000,
    S_PR_START = 14'b00000010000000,
    S_PR_RD    = 14'b00000100000000,
    S_PR_CHK   = 14'b00001000000000,
    S_FD_RD    = 14'b00010000000000,
    S_FD_CMP   = 14'b00100000000000,
    S_MERGE    = 14'b01000000000000,
    S_FIN      = 14'b10000000000000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == S_LOAD);

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    case (state_r)
      S_LOAD: begin
        cmd.load_fire = in_valid;
        if (in_valid && in_last) begin
          state_nxt = S_START;
        end
      end
      S_START: begin
        cmd.job_start = 1'b1;
        state_nxt = S_INIT;
      end
      S_INIT: begin
        cmd.init_step = 1'b1;
        if (stat.init_last) begin
          state_nxt = stat.sort_more ? S_KEY_RD : S_PR_START;
        end
      end
      S_KEY_RD: begin
        cmd.key_rd = 1'b1;
        state_nxt = S_KEY_WT;
      end
      S_KEY_WT: begin
        cmd.key_latch = 1'b1;
        state_nxt = S_SH_RD;
      end
      S_SH_RD: begin
        cmd.shift_rd = 1'b1;
        state_nxt = S_SH_CMP;
      end
      S_SH_CMP: begin
        cmd.shift_cmp = 1'b1;
        if (stat.shift_lt) begin
          state_nxt = S_SH_RD;
        end else if (stat.sort_last) begin
          state_nxt = S_PR_START;
        end else begin
          state_nxt = S_KEY_RD;
        end
      end
      S_PR_START: begin
        cmd.i_clr = 1'b1;
        state_nxt = S_PR_RD;
      end
      S_PR_RD: begin
        cmd.card_rd = 1'b1;
        state_nxt = S_PR_CHK;
      end
      S_PR_CHK: begin
        cmd.card_chk = 1'b1;
        if (stat.card_ok) begin
          state_nxt = S_FD_RD;
        end else if (stat.proc_last) begin
          state_nxt = S_FIN;
        end else begin
          state_nxt = S_PR_RD;
        end
      end
      S_FD_RD: begin
        cmd.find_rd = 1'b1;
        state_nxt = S_FD_CMP;
      end
      S_FD_CMP: begin
        cmd.find_cmp = 1'b1;
        state_nxt = (stat.is_root && stat.find_v) ? S_MERGE : S_FD_RD;
      end
      S_MERGE: begin
        cmd.merge = 1'b1;
        state_nxt = stat.proc_last ? S_FIN : S_PR_RD;
      end
      S_FIN: begin
        if (!stat.out_pend) begin
          cmd.out_load = 1'b1;
          state_nxt = S_LOAD;
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

endmodule

// ----- hdl/gpf_dp.sv -----
`timescale 1ns / 1ps

module gpf_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  gpf_pkg::ctrl_cmd_t                cmd,
  output gpf_pkg::dp_stat_t                 stat,
  input  logic                              cfg_we,
  input  logic [gpf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [gpf_pkg::POS_W-1:0]         cfg_data,
  input  logic [gpf_pkg::POS_W-1:0]         in_row,
  input  logic [gpf_pkg::POS_W-1:0]         in_col,
  input  logic [gpf_pkg::VAL_W-1:0]         in_value,
  input  logic                              out_ready,
  output logic                              out_valid,
  output logic [gpf_pkg::SUM_W-1:0]         out_total
);

  localparam int AW  = gpf_pkg::CARD_AW;
  localparam int CW  = gpf_pkg::CNT_W;
  localparam int NAW = gpf_pkg::NODE_AW;
  localparam int NW  = gpf_pkg::NODE_W;
  localparam int PW  = gpf_pkg::POS_W;
  localparam int SW  = gpf_pkg::SUM_W;

  localparam logic [PW-1:0] ROW_LIM = PW'(gpf_pkg::MAX_ROWS);
  localparam logic [PW-1:0] COL_LIM = PW'(gpf_pkg::MAX_COLS);
  localparam logic [CW-1:0] CARD_LIM = CW'(gpf_pkg::MAX_CARDS);

  gpf_pkg::card_t st_mem [gpf_pkg::MAX_CARDS];
  gpf_pkg::card_t st_rdata_r;
  gpf_pkg::card_t key_r;
  logic [NAW-1:0] par_mem [gpf_pkg::NODES];
  logic           cap_mem [gpf_pkg::NODES];
  logic [NAW-1:0] par_rdata_r;
  logic           cap_rdata_r;

  logic [PW-1:0]  row_cfg_r, col_cfg_r;
  logic [PW-1:0]  rows_r, cols_r;
  logic [CW-1:0]  cnt_r;
  logic [CW-1:0]  i_r;
  logic [AW-1:0]  j_r;
  logic [NAW-1:0] node_r;
  logic [NAW-1:0] x_r, ru_r;
  logic           cu_r, find_v_r;
  logic [SW-1:0]  sum_r;
  logic [SW-1:0]  out_r;
  logic           out_valid_r;

  logic [PW-1:0]  rows_clamp, cols_clamp;
  logic [NW-1:0]  nodes_m1;
  logic [AW-1:0]  st_raddr;
  logic           st_re;
  logic           st_we;
  logic [AW-1:0]  st_waddr;
  gpf_pkg::card_t st_wdata;
  logic [NW-1:0]  v_node;
  logic           same_root, take;
  logic [SW:0]    sum_ext;

  always_comb begin
    rows_clamp = row_cfg_r;
    if (row_cfg_r == '0) begin
      rows_clamp = PW'(1);
    end else if (row_cfg_r > ROW_LIM) begin
      rows_clamp = ROW_LIM;
    end
    cols_clamp = col_cfg_r;
    if (col_cfg_r == '0) begin
      cols_clamp = PW'(1);
    end else if (col_cfg_r > COL_LIM) begin
      cols_clamp = COL_LIM;
    end
  end

  assign nodes_m1 = NW'(rows_r) + NW'(cols_r) - NW'(1);
  assign v_node   = NW'(rows_r) + NW'(st_rdata_r.col) - NW'(1);

  // status toward the controller
  always_comb begin
    stat.init_last = (NW'(node_r) == nodes_m1);
    stat.sort_more = (i_r < cnt_r);
    stat.shift_lt  = (j_r != '0) && (st_rdata_r.value < key_r.value);
    stat.sort_last = ((i_r + CW'(1)) >= cnt_r);
    stat.card_ok   = (st_rdata_r.row != '0) && (st_rdata_r.row <= rows_r) &&
                     (st_rdata_r.col != '0) && (st_rdata_r.col <= cols_r);
    stat.is_root   = (par_rdata_r == x_r);
    stat.find_v    = find_v_r;
    stat.proc_last = ((i_r + CW'(1)) >= cnt_r);
    stat.out_pend  = out_valid_r;
  end

  // card store ports
  always_comb begin
    st_re    = cmd.key_rd | cmd.card_rd | cmd.shift_rd;
    st_raddr = cmd.shift_rd ? (j_r - AW'(1)) : i_r[AW-1:0];
    st_we    = 1'b0;
    st_waddr = cnt_r[AW-1:0];
    st_wdata = '{row: in_row, col: in_col, value: in_value};
    if (cmd.load_fire) begin
      st_we = (cnt_r < CARD_LIM);
    end else if (cmd.shift_cmp) begin
      st_we    = 1'b1;
      st_waddr = j_r;
      st_wdata = stat.shift_lt ? st_rdata_r : key_r;
    end
  end

  always_ff @(posedge clk) begin
    if (st_we) begin
      st_mem[st_waddr] <= st_wdata;
    end
    if (st_re) begin
      st_rdata_r <= st_mem[st_raddr];
    end
  end

  // merge decision on the two roots
  assign same_root = (ru_r == x_r);
  assign take      = same_root ? cu_r : (cu_r | cap_rdata_r);

  always_ff @(posedge clk) begin
    if (cmd.init_step) begin
      par_mem[node_r] <= node_r;
      cap_mem[node_r] <= 1'b1;
    end else if (cmd.merge && take) begin
      if (same_root) begin
        cap_mem[ru_r] <= 1'b0;
      end else begin
        par_mem[ru_r] <= x_r;
        cap_mem[x_r]  <= cu_r & cap_rdata_r;
      end
    end
    if (cmd.find_rd) begin
      par_rdata_r <= par_mem[x_r];
      cap_rdata_r <= cap_mem[x_r];
    end
  end

  assign sum_ext = {1'b0, sum_r} + (SW + 1)'(st_rdata_r.value);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_cfg_r   <= ROW_LIM;
      col_cfg_r   <= COL_LIM;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we && (cfg_index == gpf_pkg::REG_ROW_COUNT)) begin
        row_cfg_r <= cfg_data;
      end
      if (cfg_we && (cfg_index == gpf_pkg::REG_COL_COUNT)) begin
        col_cfg_r <= cfg_data;
      end
      if (cmd.load_fire && (cnt_r < CARD_LIM)) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (cmd.out_load) begin
        cnt_r <= '0;
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.job_start) begin
      rows_r <= rows_clamp;
      cols_r <= cols_clamp;
      node_r <= '0;
      i_r    <= CW'(1);
      sum_r  <= '0;
    end
    if (cmd.init_step) begin
      node_r <= node_r + NAW'(1);
    end
    if (cmd.key_latch) begin
      key_r <= st_rdata_r;
      j_r   <= i_r[AW-1:0];
    end
    if (cmd.shift_cmp) begin
      if (stat.shift_lt) begin
        j_r <= j_r - AW'(1);
      end else begin
        i_r <= i_r + CW'(1);
      end
    end
    if (cmd.i_clr) begin
      i_r <= '0;
    end
    if (cmd.card_chk) begin
      if (stat.card_ok) begin
        x_r      <= NAW'(st_rdata_r.row - PW'(1));
        find_v_r <= 1'b0;
      end else begin
        i_r <= i_r + CW'(1);
      end
    end
    if (cmd.find_cmp) begin
      if (stat.is_root) begin
        if (!find_v_r) begin
          ru_r     <= x_r;
          cu_r     <= cap_rdata_r;
          x_r      <= v_node[NAW-1:0];
          find_v_r <= 1'b1;
        end
      end else begin
        x_r <= par_rdata_r;
      end
    end
    if (cmd.merge) begin
      i_r <= i_r + CW'(1);
      if (take) begin
        sum_r <= sum_ext[SW] ? {SW{1'b1}} : sum_ext[SW-1:0];
      end
    end
    if (cmd.out_load) begin
      out_r <= sum_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_total = out_r;

endmodule

// ----- hdl/greedy_pseudoforest_max_weight_core.sv -----
`timescale 1ns / 1ps

// Channel   Port     Direction  Transaction
// --------  -------  ---------  ------------------------------------------
// cards     in_card  sink       one card: row, column, value, last mark
// result    out_res  source     total weight of one job
// config    cfg_wr   sink       write of row_count (0) or col_count (1)
//
// Cards load at one per cycle while the block is in its load phase.
// After the last card the block is busy with table setup over all R + C
// nodes, an insertion sort of the N cards by falling value in the card
// store, then a pass over the sorted cards that reads the parent memory
// for each in-range card to find both roots before the merge decision.
// Reset is synchronous, active low; configuration writes are always taken.
// A finished total waits in the output register; the next job loads while it
// waits, and only the end of that next job stalls until the total is taken.

module greedy_pseudoforest_max_weight_core (
  input  logic                clk,
  input  logic                rst_n,
  gpf_card_if.sink            in_card,
  gpf_result_if.source        out_res,
  gpf_cfg_if.sink             cfg_wr
);

  gpf_pkg::ctrl_cmd_t cmd;
  gpf_pkg::dp_stat_t  stat;

  // Configuration registers live in the datapath and never stall a write.
  assign cfg_wr.ready = 1'b1;

  gpf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_card.valid),
    .in_last  (in_card.last_card),
    .in_ready (in_card.ready),
    .cmd      (cmd),
    .stat     (stat)
  );

  gpf_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .cfg_we    (cfg_wr.valid),
    .cfg_index (cfg_wr.index),
    .cfg_data  (cfg_wr.data),
    .in_row    (in_card.card_row),
    .in_col    (in_card.card_col),
    .in_value  (in_card.card_value),
    .out_ready (out_res.ready),
    .out_valid (out_res.valid),
    .out_total (out_res.total_weight)
  );

`ifndef NO_ASSERTIONS
  // A new total must never overwrite one that has not been taken.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.out_load && stat.out_pend))
    else $error("total loaded while previous result pending");

  // The datapath performs at most one job action per cycle.
  a_one_action: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.init_step, cmd.key_latch, cmd.shift_cmp, cmd.card_chk,
              cmd.find_cmp, cmd.merge, cmd.out_load}))
    else $error("conflicting datapath commands");

  // Taking the last card of a job drops the card ready straight away; no card is taken until the job finishes.
  a_busy_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (in_card.valid && in_card.ready && in_card.last_card) |=> !in_card.ready)
    else $error("card accepted right after last card");
`endif

endmodule

// ----- test/tb_greedy_pseudoforest_max_weight_core.sv -----
`timescale 1ns / 1ps

module tb_greedy_pseudoforest_max_weight_core;

  // The sort is quadratic in the job size, so most jobs are small. A full
  // store of 1024 cards costs the most sorting plus the union-find walks,
  // and the run limit below allows for many such jobs.
  localparam longint unsigned TOTAL_CAP = (64'd1 << gpf_pkg::SUM_W) - 1;

  logic clk;
  logic rst_n;

  gpf_card_if   card_ch ();
  gpf_result_if res_ch ();
  gpf_cfg_if    cfg_ch ();

  greedy_pseudoforest_max_weight_core i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_card (card_ch.sink),
    .out_res (res_ch.source),
    .cfg_wr  (cfg_ch.sink)
  );

  // Shadow copies of the configuration registers and of the job being loaded.
  logic [gpf_pkg::POS_W-1:0] cur_rows;
  logic [gpf_pkg::POS_W-1:0] cur_cols;
  gpf_pkg::card_t            job_cards[$];
  logic [gpf_pkg::SUM_W-1:0] pending_totals[$];
  int                        fail_count;
  int                        totals_seen;
  int                        stall_mode;
  bit                        hold_sender;

  initial begin
    clk = 1'b0;
  end

  always begin
    #5 clk = ~clk;
  end

  // Runs the greedy pseudoforest pass over the stored job and returns the
  // saturated total. Parents and capacities live in local arrays per job.
  function automatic logic [gpf_pkg::SUM_W-1:0] max_pseudoforest_total(
      input gpf_pkg::card_t cards[$], input int rows_reg, input int cols_reg);
    int               rows;
    int               cols;
    int               parent[gpf_pkg::NODES];
    int               cap[gpf_pkg::NODES];
    int               ru;
    int               rv;
    bit               take;
    gpf_pkg::card_t   key;
    gpf_pkg::card_t   sorted[$];
    int               j;
    longint unsigned  sum;
    rows = (rows_reg < 1) ? 1 : (rows_reg > gpf_pkg::MAX_ROWS) ? gpf_pkg::MAX_ROWS : rows_reg;
    cols = (cols_reg < 1) ? 1 : (cols_reg > gpf_pkg::MAX_COLS) ? gpf_pkg::MAX_COLS : cols_reg;
    for (int n = 0; n < gpf_pkg::NODES; n++) begin
      parent[n] = n;
      cap[n]    = 1;
    end
    sorted = cards;
    for (int i = 1; i < sorted.size(); i++) begin
      key = sorted[i];
      j = i;
      while (j > 0 && sorted[j-1].value < key.value) begin
        sorted[j] = sorted[j-1];
        j--;
      end
      sorted[j] = key;
    end
    sum = 0;
    foreach (sorted[i]) begin
      if (sorted[i].row < 1 || sorted[i].row > rows || sorted[i].col < 1 ||
          sorted[i].col > cols) begin
        continue;
      end
      ru = sorted[i].row - 1;
      while (parent[ru] != ru) ru = parent[ru];
      rv = rows + sorted[i].col - 1;
      while (parent[rv] != rv) rv = parent[rv];
      take = 1'b0;
      if (ru == rv) begin
        if (cap[ru] >= 1) begin
          cap[ru]--;
          take = 1'b1;
        end
      end else if (cap[ru] + cap[rv] >= 1) begin
        parent[ru] = rv;
        cap[rv] = cap[rv] + cap[ru] - 1;
        cap[ru] = 0;
        take = 1'b1;
      end
      if (take) begin
        sum += sorted[i].value;
        if (sum > TOTAL_CAP) sum = TOTAL_CAP;
      end
    end
    return sum[gpf_pkg::SUM_W-1:0];
  endfunction

  // Result side: the receiver stalls on a mode that the tests change, and
  // every accepted total is compared with the oldest prediction.
  always @(posedge clk) begin
    if (!rst_n) begin
      res_ch.ready <= 1'b0;
    end else begin
      case (stall_mode)
        0: res_ch.ready <= 1'b1;
        1: res_ch.ready <= ($urandom_range(0, 3) != 0);
        default: res_ch.ready <= ($urandom_range(0, 9) == 0);
      endcase
      if (res_ch.valid && res_ch.ready) begin
        totals_seen++;
        if (pending_totals.size() == 0) begin
          $display("%0t: unexpected total, expected none, actual %0d", $time,
                   res_ch.total_weight);
          fail_count++;
        end else begin
          if (res_ch.total_weight !== pending_totals[0]) begin
            $display("%0t: total_weight mismatch, expected %0d, actual %0d", $time,
                     pending_totals[0], res_ch.total_weight);
            fail_count++;
          end
          void'(pending_totals.pop_front());
        end
      end
    end
  end

  // Sends one card and, when it is accepted, folds it into the shadow job.
  // Cards beyond the store size are dropped, as the block drops them.
  task automatic send_card(input logic [gpf_pkg::POS_W-1:0] row,
                           input logic [gpf_pkg::POS_W-1:0] col,
                           input logic [gpf_pkg::VAL_W-1:0] value, input logic last);
    gpf_pkg::card_t c;
    card_ch.valid      <= 1'b1;
    card_ch.card_row   <= row;
    card_ch.card_col   <= col;
    card_ch.card_value <= value;
    card_ch.last_card  <= last;
    do @(posedge clk); while (!card_ch.ready);
    c.row   = row;
    c.col   = col;
    c.value = value;
    if (job_cards.size() < gpf_pkg::MAX_CARDS) job_cards = {job_cards, c};
    if (last) begin
      pending_totals = {pending_totals,
                        max_pseudoforest_total(job_cards, cur_rows, cur_cols)};
      job_cards.delete();
    end
  endtask

  // Drops valid for a random gap now and then, so the sender works in bursts.
  task automatic sender_gap();
    if ($urandom_range(0, 5) == 0) begin
      card_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    card_ch.valid <= 1'b0;
    while (pending_totals.size() != 0) @(posedge clk);
    // Let the block sit idle before the configuration changes.
    repeat (50) @(posedge clk);
  endtask

  task automatic write_reg(input logic [gpf_pkg::CFG_IDX_W-1:0] idx,
                           input logic [gpf_pkg::POS_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    if (idx == gpf_pkg::REG_ROW_COUNT) cur_rows = data;
    else cur_cols = data;
  endtask

  task automatic set_counts(input logic [gpf_pkg::POS_W-1:0] rows,
                            input logic [gpf_pkg::POS_W-1:0] cols);
    wait_idle();
    write_reg(gpf_pkg::REG_ROW_COUNT, rows);
    write_reg(gpf_pkg::REG_COL_COUNT, cols);
    cfg_ch.valid <= 1'b0;
  endtask

  // Random value with frequent extremes and frequent ties.
  function automatic logic [gpf_pkg::VAL_W-1:0] pick_value();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return gpf_pkg::VAL_W'($urandom_range(0, 7));
      default: return $urandom();
    endcase
  endfunction

  // Sends one random job of n cards. Rows and columns mostly fall inside the
  // configured area, with some outside it and some across the whole field.
  task automatic send_random_job(input int n, input int max_row, input int max_col,
                                 input bit bursty);
    logic [gpf_pkg::POS_W-1:0] r;
    logic [gpf_pkg::POS_W-1:0] c;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        r = gpf_pkg::POS_W'($urandom());
        c = gpf_pkg::POS_W'($urandom());
      end else begin
        r = gpf_pkg::POS_W'($urandom_range(1, max_row));
        c = gpf_pkg::POS_W'($urandom_range(1, max_col));
      end
      send_card(r, c, pick_value(), i == n - 1);
      if (bursty && !hold_sender) sender_gap();
    end
  endtask

  // Directed: value and position extremes, out-of-range cards, large totals
  // and a job made of one card only.
  task automatic test_directed();
    set_counts(10'd4, 10'd4);
    send_card(10'd1, 10'd1, '1, 1'b1);
    send_card(10'd4, 10'd4, '0, 1'b0);
    send_card(10'd0, 10'd1, 32'd99, 1'b0);
    send_card(10'd5, 10'd2, 32'd98, 1'b0);
    send_card(10'd2, 10'd0, 32'd97, 1'b0);
    send_card(10'd2, 10'd5, 32'd96, 1'b0);
    send_card(10'h3ff, 10'h3ff, 32'd95, 1'b0);
    send_card(10'd1, 10'd1, 32'd7, 1'b0);
    send_card(10'd1, 10'd1, 32'd7, 1'b0);
    send_card(10'd1, 10'd1, 32'd7, 1'b1);
    set_counts(10'd512, 10'd512);
    for (int i = 0; i < 12; i++) begin
      send_card(gpf_pkg::POS_W'(i + 1), gpf_pkg::POS_W'(512 - i), '1, i == 11);
    end
  endtask

  // A full store of many maximal cards on distinct edges drives the total
  // toward its top; the store is filled and then overrun, which drops cards.
  task automatic test_store_full();
    set_counts(10'd512, 10'd512);
    for (int i = 0; i < gpf_pkg::MAX_CARDS + 3; i++) begin
      send_card(gpf_pkg::POS_W'((i % 512) + 1),
                gpf_pkg::POS_W'(((i * 7 + i / 512) % 512) + 1),
                (i % 3 == 0) ? '1 : $urandom(), i == gpf_pkg::MAX_CARDS + 2);
    end
  endtask

  // Register extremes: zero counts as one, values above the bound saturate.
  task automatic test_register_extremes();
    set_counts(10'd0, 10'd0);
    send_random_job(6, 3, 3, 1'b0);
    set_counts(10'h3ff, 10'h3ff);
    send_random_job(8, 600, 600, 1'b0);
    set_counts(10'd1, 10'd512);
    send_random_job(8, 2, 512, 1'b0);
    set_counts(10'd513, 10'd1);
    send_random_job(8, 512, 2, 1'b0);
  endtask

  // Random jobs under several settings and receiver stall modes. The
  // sender pauses once until every outstanding total has been taken.
  task automatic test_random_jobs();
    int sent;
    int n;
    int area;
    bit held;
    sent = 0;
    held = 1'b0;
    for (int phase = 0; phase < 6; phase++) begin
      area = (phase == 0) ? 3 : (phase == 1) ? 8 : (phase == 2) ? 30 : 512;
      set_counts(gpf_pkg::POS_W'(area), gpf_pkg::POS_W'((phase == 4) ? 5 : area));
      stall_mode = phase % 3;
      while (sent < (phase + 1) * 130) begin
        n = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
        send_random_job(n, area + 1, ((phase == 4) ? 5 : area) + 1, 1'b1);
        sent += n;
        if (phase == 2 && !held) begin
          held = 1'b1;
          hold_sender = 1'b1;
          card_ch.valid <= 1'b0;
          while (pending_totals.size() != 0) @(posedge clk);
          hold_sender = 1'b0;
        end
      end
    end
    stall_mode = 0;
  endtask

  initial begin
    rst_n              = 1'b0;
    card_ch.valid      = 1'b0;
    card_ch.card_row   = '0;
    card_ch.card_col   = '0;
    card_ch.card_value = '0;
    card_ch.last_card  = 1'b0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.index       = gpf_pkg::REG_ROW_COUNT;
    cfg_ch.data        = '0;
    cur_rows           = 10'd512;
    cur_cols           = 10'd512;
    fail_count         = 0;
    totals_seen        = 0;
    stall_mode         = 0;
    hold_sender        = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_register_extremes();
    test_random_jobs();
    test_store_full();
    wait_idle();
    repeat (100) @(posedge clk);

    if (fail_count == 0 && pending_totals.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // A full store job takes by far the longest; every other job is far shorter.
  initial begin
    #500ms;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
